### rtl/ddo_pkg.sv
// Package for diff_drive_odometry: constants, types, arctangent table and helpers.
// No dependencies.
`default_nettype none
package ddo_pkg;
	localparam int ATAN_ENTRIES = 30;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIFF  = 7'b0000010,
		ST_MUL   = 7'b0000100,
		ST_TRIG  = 7'b0001000,
		ST_SCALE = 7'b0010000,
		ST_QUAT  = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	typedef enum logic [2:0] {
		REG_MPS    = 3'd0,
		REG_TPS    = 3'd1,
		REG_SWAP   = 3'd2,
		REG_INV1   = 3'd3,
		REG_INV2   = 3'd4
	} reg_idx_t;

	function automatic logic [29:0] atan_lut(input logic [4:0] i);
		logic [29:0] r;
		begin
			case (i)
				5'd0: r = 30'h20000000;  5'd1: r = 30'h12E4051E;
				5'd2: r = 30'h09FB385B;  5'd3: r = 30'h051111D4;
				5'd4: r = 30'h028B0D43;  5'd5: r = 30'h0145D7E1;
				5'd6: r = 30'h00A2F61E;  5'd7: r = 30'h00517C55;
				5'd8: r = 30'h0028BE53;  5'd9: r = 30'h00145F2F;
				5'd10: r = 30'h000A2F98; 5'd11: r = 30'h000517CC;
				5'd12: r = 30'h00028BE6; 5'd13: r = 30'h000145F3;
				5'd14: r = 30'h0000A2F9; 5'd15: r = 30'h0000517C;
				5'd16: r = 30'h000028BE; 5'd17: r = 30'h0000145F;
				5'd18: r = 30'h00000A2F; 5'd19: r = 30'h00000517;
				5'd20: r = 30'h0000028B; 5'd21: r = 30'h00000145;
				5'd22: r = 30'h000000A2; 5'd23: r = 30'h00000051;
				5'd24: r = 30'h00000028; 5'd25: r = 30'h00000014;
				5'd26: r = 30'h0000000A; 5'd27: r = 30'h00000005;
				5'd28: r = 30'h00000002; 5'd29: r = 30'h00000001;
				default: r = 30'h0;
			endcase
			return r;
		end
	endfunction

	// clamp a 34-bit signed value to 32 bits
	function automatic logic [31:0] sat32(input logic signed [33:0] v);
		begin
			if (v > 34'sd2147483647) return 32'h7FFFFFFF;
			else if (v < -34'sd2147483648) return 32'h80000000;
			else return v[31:0];
		end
	endfunction

	// round Q1.30 to Q1.15 half up and clamp
	function automatic logic [15:0] to_q15(input logic signed [33:0] v);
		logic signed [33:0] r;
		begin
			r = (v + 34'sd16384) >>> 15;
			if (r > 34'sd32767) return 16'h7FFF;
			else if (r < -34'sd32768) return 16'h8000;
			else return r[15:0];
		end
	endfunction
endpackage
`default_nettype wire

### rtl/ddo_if.sv
// Valid/ready channel interfaces for diff_drive_odometry words.
// No dependencies.
`default_nettype none
interface ddo_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] enc_count_a;
	logic signed [31:0] enc_count_b;
	modport source (output valid, enc_count_a, enc_count_b, input ready);
	modport sink (input valid, enc_count_a, enc_count_b, output ready);
endinterface

interface ddo_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] pose_x;
	logic signed [31:0] pose_y;
	logic [31:0] heading_angle;
	logic signed [31:0] step_dx;
	logic signed [31:0] step_dy;
	logic signed [31:0] step_dtheta;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_z;
	modport source (output valid, pose_x, pose_y, heading_angle, step_dx, step_dy,
		step_dtheta, quat_w, quat_z, input ready);
	modport sink (input valid, pose_x, pose_y, heading_angle, step_dx, step_dy,
		step_dtheta, quat_w, quat_z, output ready);
endinterface
`default_nettype wire

### rtl/diff_drive_odometry.sv
// One word at a time: a word passes through the bit-serial multipliers, a CORDIC pass
// for the heading, the serial scaling multipliers and a second CORDIC pass for the
// quaternion; the next word is accepted in the cycle after the result is loaded, and
// a result still waiting to be taken holds the next one.
// Reset (arst_n low, asynchronous): registers to defaults, counts, pose, heading zero.
// Depends on ddo_pkg and ddo_if.
`default_nettype none
module diff_drive_odometry #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ddo_in_if.sink           in_ch,
	ddo_out_if.source        out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int IW = $clog2(TRIG_ITERATIONS + 1);

	logic [31:0] mps_q, tps_q;
	logic swap_q, inv1_q, inv2_q;
	logic [31:0] prev_a_q, prev_b_q, px_q, py_q, head_q;
	ddo_pkg::state_t st_q;

	// config registers
	wire wr = psel && penable && pwrite;
	wire [2:0] ridx = paddr[4:2];
	assign pready = 1'b1;
	always_comb begin
		case (ridx)
			ddo_pkg::REG_MPS:  prdata = mps_q;
			ddo_pkg::REG_TPS:  prdata = tps_q;
			ddo_pkg::REG_SWAP: prdata = {31'd0, swap_q};
			ddo_pkg::REG_INV1: prdata = {31'd0, inv1_q};
			ddo_pkg::REG_INV2: prdata = {31'd0, inv2_q};
			default:           prdata = 32'd0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mps_q <= 32'd4294967; tps_q <= 32'd65536;
			swap_q <= 1'b1; inv1_q <= 1'b0; inv2_q <= 1'b0;
		end else if (wr && paddr[1:0] == 2'b00) begin
			case (ridx)
				ddo_pkg::REG_MPS:  mps_q <= pwdata;
				ddo_pkg::REG_TPS:  tps_q <= pwdata;
				ddo_pkg::REG_SWAP: swap_q <= pwdata[0];
				ddo_pkg::REG_INV1: inv1_q <= pwdata[0];
				ddo_pkg::REG_INV2: inv2_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// wheel deltas with inversion and swap
	logic [31:0] d1u, d2u, e1, e2;
	always_comb begin
		d1u = in_ch.enc_count_a - prev_a_q;
		d2u = in_ch.enc_count_b - prev_b_q;
		if (inv1_q) d1u = 32'd0 - d1u;
		if (inv2_q) d2u = 32'd0 - d2u;
		e1 = swap_q ? d2u : d1u;
		e2 = swap_q ? d1u : d2u;
	end

	// sum and diff, sign and magnitude
	logic sum_neg_q, diff_neg_q;
	logic [32:0] sum_mag_q, diff_mag_q;
	// bit-serial multipliers: shared shift counter
	logic [65:0] acc_u_q, acc_t_q;
	logic [32:0] mu_sh_q, mt_sh_q;
	logic [5:0] bit_q;
	// cordic
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [IW-1:0] it_q;
	logic flip_q, pass_q;
	logic signed [49:0] uw_q;
	logic signed [33:0] cos_q, sin_q;
	logic [31:0] dth_q, newh_q;
	// scaling: serial multiply |uw| by |trig|
	logic [48:0] smag_q;
	logic [31:0] sx_q, sy_q;
	logic [80:0] ax_q, ay_q;
	logic sxn_q, syn_q;
	// saturated step deltas held for the result
	logic [31:0] sdx_q, sdy_q;

	logic signed [33:0] sum_w, diff_w;
	assign sum_w  = {{2{e1[31]}}, e1} + {{2{e2[31]}}, e2};
	assign diff_w = {{2{e2[31]}}, e2} - {{2{e1[31]}}, e1};

	assign in_ch.ready = (st_q == ddo_pkg::ST_IDLE);

	// cordic step
	logic signed [33:0] xs, ys;
	logic [29:0] at;
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;
	assign at = ddo_pkg::atan_lut(5'(it_q));

	function automatic logic signed [33:0] start_z(input logic [31:0] ang);
		logic [31:0] a;
		begin
			a = (ang[31:30] == 2'b01 || ang[31:30] == 2'b10) ? ang + 32'h80000000 : ang;
			return {{2{a[31]}}, a};
		end
	endfunction

	// product >> 30, magnitude clamped to 2^32 ahead of saturation
	logic signed [33:0] dx_w, dy_w;
	logic [32:0] mx_w, my_w;
	logic [31:0] sdx_w, sdy_w;
	assign mx_w = (|ax_q[80:62]) ? 33'h100000000 : ax_q[62:30];
	assign my_w = (|ay_q[80:62]) ? 33'h100000000 : ay_q[62:30];
	assign dx_w = sxn_q ? -$signed({1'b0, mx_w}) : $signed({1'b0, mx_w});
	assign dy_w = syn_q ? -$signed({1'b0, my_w}) : $signed({1'b0, my_w});
	assign sdx_w = ddo_pkg::sat32(dx_w);
	assign sdy_w = ddo_pkg::sat32(dy_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ddo_pkg::ST_IDLE;
			prev_a_q <= '0; prev_b_q <= '0;
			px_q <= '0; py_q <= '0; head_q <= '0;
			out_ch.valid <= 1'b0;
			bit_q <= '0; it_q <= '0; pass_q <= 1'b0;
		end else begin
			// result valid: load when the register is free, drop when taken
			if (st_q == ddo_pkg::ST_OUT && (!out_ch.valid || out_ch.ready))
				out_ch.valid <= 1'b1;
			else if (out_ch.ready)
				out_ch.valid <= 1'b0;
			case (st_q)
				ddo_pkg::ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						prev_a_q <= in_ch.enc_count_a;
						prev_b_q <= in_ch.enc_count_b;
						sum_neg_q <= sum_w[33];
						diff_neg_q <= diff_w[33];
						sum_mag_q <= sum_w[33] ? 33'(-sum_w) : sum_w[32:0];
						diff_mag_q <= diff_w[33] ? 33'(-diff_w) : diff_w[32:0];
						st_q <= ddo_pkg::ST_DIFF;
					end
				end
				ddo_pkg::ST_DIFF: begin
					mu_sh_q <= sum_mag_q; mt_sh_q <= diff_mag_q;
					acc_u_q <= '0; acc_t_q <= '0; bit_q <= '0;
					st_q <= ddo_pkg::ST_MUL;
				end
				// one multiplier bit per cycle for travel and turn
				ddo_pkg::ST_MUL: begin
					if (mu_sh_q[0]) acc_u_q <= acc_u_q + (66'(mps_q) << bit_q);
					if (mt_sh_q[0]) acc_t_q <= acc_t_q + (66'(tps_q) << bit_q);
					mu_sh_q <= mu_sh_q >> 1; mt_sh_q <= mt_sh_q >> 1;
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd32) begin
						st_q <= ddo_pkg::ST_TRIG;
						pass_q <= 1'b0; it_q <= '0;
						cx_q <= ddo_pkg::CORDIC_GAIN; cy_q <= '0;
						cz_q <= start_z(head_q);
						flip_q <= head_q[31:30] == 2'b01 || head_q[31:30] == 2'b10;
					end
				end
				ddo_pkg::ST_TRIG: begin
					if (bit_q != 6'd0) begin
						// latch travel and turn once
						bit_q <= '0;
						uw_q <= sum_neg_q ? -$signed(50'(acc_u_q >> 17))
							: $signed(50'(acc_u_q >> 17));
						dth_q <= diff_neg_q ? 32'd0 - 32'(acc_t_q >> 16) : 32'(acc_t_q >> 16);
					end
					if (it_q == IW'(TRIG_ITERATIONS)) begin
						if (!pass_q) begin
							cos_q <= flip_q ? -cx_q : cx_q;
							sin_q <= flip_q ? -cy_q : cy_q;
							newh_q <= head_q + dth_q;
							st_q <= ddo_pkg::ST_SCALE;
							bit_q <= '0;
						end else begin
							st_q <= ddo_pkg::ST_OUT;
						end
					end else begin
						it_q <= it_q + 1'b1;
						if (!cz_q[33]) begin
							cx_q <= cx_q - ys; cy_q <= cy_q + xs;
							cz_q <= cz_q - $signed({4'b0, at});
						end else begin
							cx_q <= cx_q + ys; cy_q <= cy_q - xs;
							cz_q <= cz_q + $signed({4'b0, at});
						end
					end
				end
				// serial |uw| * |cos|, |uw| * |sin|
				ddo_pkg::ST_SCALE: begin
					if (bit_q == 6'd0 && !pass_q) begin
						pass_q <= 1'b1;
						smag_q <= uw_q[49] ? 49'(-uw_q) : 49'(uw_q);
						sx_q <= cos_q[33] ? 32'(-cos_q) : cos_q[31:0];
						sy_q <= sin_q[33] ? 32'(-sin_q) : sin_q[31:0];
						sxn_q <= uw_q[49] != cos_q[33];
						syn_q <= uw_q[49] != sin_q[33];
						ax_q <= '0; ay_q <= '0;
						bit_q <= 6'd1;
					end else if (bit_q <= 6'd32) begin
						if (sx_q[0]) ax_q <= ax_q + (81'(smag_q) << (bit_q - 6'd1));
						if (sy_q[0]) ay_q <= ay_q + (81'(smag_q) << (bit_q - 6'd1));
						sx_q <= sx_q >> 1; sy_q <= sy_q >> 1;
						bit_q <= bit_q + 6'd1;
					end else begin
						st_q <= ddo_pkg::ST_QUAT;
					end
				end
				ddo_pkg::ST_QUAT: begin
					sdx_q <= sdx_w;
					sdy_q <= sdy_w;
					head_q <= newh_q;
					it_q <= '0; bit_q <= '0;
					cx_q <= ddo_pkg::CORDIC_GAIN; cy_q <= '0;
					cz_q <= start_z({1'b0, newh_q[31:1]});
					flip_q <= newh_q[31];
					st_q <= ddo_pkg::ST_TRIG;
				end
				ddo_pkg::ST_OUT: begin
					if (!out_ch.valid || out_ch.ready) begin
						out_ch.pose_x <= px_q;
						out_ch.pose_y <= py_q;
						out_ch.heading_angle <= head_q;
						out_ch.step_dx <= sdx_q;
						out_ch.step_dy <= sdy_q;
						out_ch.step_dtheta <= dth_q;
						out_ch.quat_w <= ddo_pkg::to_q15(flip_q ? -cx_q : cx_q);
						out_ch.quat_z <= ddo_pkg::to_q15(flip_q ? -cy_q : cy_q);
						pass_q <= 1'b0;
						st_q <= ddo_pkg::ST_IDLE;
					end
				end
				default: st_q <= ddo_pkg::ST_IDLE;
			endcase
			// position update uses full signed step with saturation
			if (st_q == ddo_pkg::ST_QUAT) begin
				px_q <= ddo_pkg::sat32($signed({{2{px_q[31]}}, px_q})
					+ $signed({{2{sdx_w[31]}}, sdx_w}));
				py_q <= ddo_pkg::sat32($signed({{2{py_q[31]}}, py_q})
					+ $signed({{2{sdy_w[31]}}, sdy_w}));
			end
		end
	end

	// checks
	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q))
		else $error("state not one-hot");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ddo_pkg::ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ddo_pkg::ST_OUT) |=> out_ch.valid) else $error("result lost");
endmodule
`default_nettype wire
